// ===== hw/rtl/npc_pkg.sv =====
package npc_pkg;

   // Cap on the per-polygon emitted count: the smaller of 2*MAX_VERTS and 4095
   localparam int MAX_VERTS = 1024;
   localparam int COUNT_CAP_INT = (2 * MAX_VERTS < 4095) ? 2 * MAX_VERTS : 4095;
   localparam logic [11:0] COUNT_CAP = 12'(COUNT_CAP_INT);

   // Configuration register indexes
   typedef logic [0:0] csr_addr_type;
   localparam csr_addr_type CSR_MIN_Z    = 1'b0;
   localparam csr_addr_type CSR_NEAR_EPS = 1'b1;

   localparam int DIV_STEPS = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_LOAD,
      ST_EDGE_DIST,
      ST_EDGE_SUM,
      ST_EDGE_DECIDE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT_BORDER,
      ST_EMIT_CUR,
      ST_EDGE_DONE,
      ST_EMIT_TRAILER
   } ctrl_state_type;

   typedef enum logic [2:0] {
      LERP_IDLE,
      LERP_MUL,
      LERP_DIV,
      LERP_FIX,
      LERP_DONE
   } lerp_state_type;

   typedef enum logic [1:0] {
      OUT_CUR,
      OUT_BORDER,
      OUT_TRAILER
   } out_src_type;

   typedef struct packed {
      logic        cap_in;     // latch the incoming vertex
      logic        set_first;  // it also opens a polygon
      logic        load_edge;  // load edge end points
      logic        edge_close; // closing edge: current back to first
      logic        div_start;
      logic        out_load;
      out_src_type out_src;
      logic        out_olast;
   } cmd_type;

   typedef struct packed {
      logic pin;
      logic cin;
      logic near;
      logic div_done;
      logic out_free;
      logic last;
   } status_type;

endpackage

// ===== hw/rtl/npc_lerp.sv =====
module npc_lerp (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] p,
   input  logic [31:0] c,
   input  logic [31:0] dprev,
   input  logic [32:0] sum,
   output logic [31:0] result,
   output logic        done
);
   import npc_pkg::*;

   lerp_state_type state_ff, state_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [31:0] dp_ff, dp_in;
   logic [32:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] result_ff, result_in;

   logic signed [32:0] diff;
   logic [63:0] prod;
   logic [33:0] shifted;
   logic [33:0] trial;

   assign diff    = $signed({c[31], c}) - $signed({p[31], p});
   assign prod    = mag_ff * dp_ff;
   assign shifted = {rem_ff, low_ff[31]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LERP_IDLE: if (start) state_in = LERP_MUL;
         LERP_MUL:  state_in = LERP_DIV;
         LERP_DIV:  if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = LERP_FIX;
         LERP_FIX:  state_in = LERP_DONE;
         LERP_DONE: state_in = LERP_IDLE;
         default:   state_in = LERP_IDLE;
      endcase
   end

   always_comb begin
      base_in   = base_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      dp_in     = dp_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      case (state_ff)
         LERP_IDLE: begin
            base_in = p;
            neg_in  = diff[32];
            mag_in  = diff[32] ? 32'(-diff) : diff[31:0];
            dp_in   = dprev;
            den_in  = sum;
            cnt_in  = '0;
         end
         LERP_MUL: begin
            // upper half is already below the divisor, so 32 steps give the quotient
            rem_in = {1'b0, prod[63:32]};
            low_in = prod[31:0];
         end
         LERP_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (!trial[33]) begin
               rem_in = trial[32:0];
               low_in = {low_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted[32:0];
               low_in = {low_ff[30:0], 1'b0};
            end
         end
         LERP_FIX: begin
            result_in = neg_ff ? base_ff - low_ff : base_ff + low_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LERP_IDLE;
      end else begin
         state_ff <= state_in;
      end
      base_ff   <= base_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      dp_ff     <= dp_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
   assign done   = (state_ff == LERP_DONE);

endmodule

// ===== hw/rtl/npc_datapath.sv =====
module npc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  npc_pkg::cmd_type      cmd,
   output npc_pkg::status_type   status,
   input  logic [95:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic                  csr_wen,
   input  npc_pkg::csr_addr_type csr_addr,
   input  logic [31:0]           csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [111:0]          rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import npc_pkg::*;

   logic [31:0] min_z_ff;
   logic [15:0] near_eps_ff;

   logic [31:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic        last_ff;
   logic [31:0] first_x_ff, first_y_ff, first_z_ff;
   logic [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [31:0] p_x_ff, p_y_ff, p_z_ff;
   logic [31:0] c_x_ff, c_y_ff, c_z_ff;

   logic [31:0] dprev_ff, dcur_ff;
   logic        pin_ff, cin_ff;
   logic [32:0] sum_ff;

   logic [11:0] count_ff, count_in;

   logic        out_valid_ff;
   logic        out_kind_ff, out_kept_ff, out_last_ff;
   logic [31:0] out_x_ff, out_y_ff, out_z_ff;
   logic [11:0] out_cnt_ff;

   logic signed [32:0] pdiff, cdiff;
   logic        near;
   logic [31:0] lerp_x, lerp_y;
   logic        done_x, done_y;
   logic        out_free;

   assign pdiff = $signed({p_z_ff[31], p_z_ff}) - $signed({min_z_ff[31], min_z_ff});
   assign cdiff = $signed({c_z_ff[31], c_z_ff}) - $signed({min_z_ff[31], min_z_ff});
   assign near  = sum_ff < {17'd0, near_eps_ff};
   assign out_free = !out_valid_ff || rsp_tready;

   npc_lerp u_lerp_x (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .p      (p_x_ff),
      .c      (c_x_ff),
      .dprev  (dprev_ff),
      .sum    (sum_ff),
      .result (lerp_x),
      .done   (done_x)
   );

   npc_lerp u_lerp_y (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .p      (p_y_ff),
      .c      (c_y_ff),
      .dprev  (dprev_ff),
      .sum    (sum_ff),
      .result (lerp_y),
      .done   (done_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_z_ff    <= '0;
         near_eps_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_MIN_Z:    min_z_ff    <= csr_wdata;
            CSR_NEAR_EPS: near_eps_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // vertex capture and edge end points
   always_ff @(posedge clock) begin
      if (cmd.cap_in) begin
         cur_x_ff <= req_tdata[31:0];
         cur_y_ff <= req_tdata[63:32];
         cur_z_ff <= req_tdata[95:64];
         last_ff  <= req_tlast;
      end
      if (cmd.set_first) begin
         first_x_ff <= req_tdata[31:0];
         first_y_ff <= req_tdata[63:32];
         first_z_ff <= req_tdata[95:64];
         prev_x_ff  <= req_tdata[31:0];
         prev_y_ff  <= req_tdata[63:32];
         prev_z_ff  <= req_tdata[95:64];
      end
      if (cmd.load_edge) begin
         if (cmd.edge_close) begin
            p_x_ff <= cur_x_ff;   p_y_ff <= cur_y_ff;   p_z_ff <= cur_z_ff;
            c_x_ff <= first_x_ff; c_y_ff <= first_y_ff; c_z_ff <= first_z_ff;
         end else begin
            p_x_ff <= prev_x_ff;  p_y_ff <= prev_y_ff;  p_z_ff <= prev_z_ff;
            c_x_ff <= cur_x_ff;   c_y_ff <= cur_y_ff;   c_z_ff <= cur_z_ff;
         end
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
         prev_z_ff <= cur_z_ff;
      end
      // distances are registered from the end points, and the sum from the registered distances
      dprev_ff <= pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
      dcur_ff  <= cdiff[32] ? 32'(-cdiff) : cdiff[31:0];
      pin_ff   <= !pdiff[32];
      cin_ff   <= !cdiff[32];
      sum_ff   <= {1'b0, dprev_ff} + {1'b0, dcur_ff};
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.out_load) begin
         if (cmd.out_src == OUT_TRAILER) begin
            count_in = '0;
         end else if (count_ff < COUNT_CAP) begin
            count_in = count_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_last_ff <= cmd.out_olast;
         case (cmd.out_src)
            OUT_CUR: begin
               out_kind_ff <= 1'b0;
               out_kept_ff <= 1'b0;
               out_cnt_ff  <= '0;
               out_x_ff    <= c_x_ff;
               out_y_ff    <= c_y_ff;
               out_z_ff    <= c_z_ff;
            end
            OUT_BORDER: begin
               out_kind_ff <= 1'b0;
               out_kept_ff <= 1'b0;
               out_cnt_ff  <= '0;
               out_x_ff    <= near ? c_x_ff : lerp_x;
               out_y_ff    <= near ? c_y_ff : lerp_y;
               out_z_ff    <= near ? c_z_ff : min_z_ff;
            end
            default: begin
               out_kind_ff <= 1'b1;
               out_kept_ff <= count_ff > 12'd2;
               out_cnt_ff  <= count_ff;
               out_x_ff    <= '0;
               out_y_ff    <= '0;
               out_z_ff    <= '0;
            end
         endcase
      end
   end

   assign status.pin      = pin_ff;
   assign status.cin      = cin_ff;
   assign status.near     = near;
   assign status.div_done = done_x && done_y;
   assign status.out_free = out_free;
   assign status.last     = last_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_cnt_ff, out_kept_ff, out_z_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_CAP)
      else $error("emitted count above cap");

endmodule

// ===== hw/rtl/npc_ctrl.sv =====
module npc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   input  npc_pkg::status_type status,
   output npc_pkg::cmd_type    cmd
);
   import npc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic have_first_ff, have_first_in;
   logic edge_close_ff, edge_close_in;
   logic accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      have_first_in = have_first_ff;
      edge_close_in = edge_close_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               have_first_in = 1'b1;
               edge_close_in = !have_first_ff;
               if (have_first_ff || req_tlast) begin
                  state_in = ST_EDGE_LOAD;
               end
            end
         end
         ST_EDGE_LOAD:   state_in = ST_EDGE_DIST;
         ST_EDGE_DIST:   state_in = ST_EDGE_SUM;
         ST_EDGE_SUM:    state_in = ST_EDGE_DECIDE;
         ST_EDGE_DECIDE: begin
            if (status.pin && status.cin) begin
               state_in = ST_EMIT_CUR;
            end else if (status.pin != status.cin) begin
               state_in = status.near ? ST_EMIT_BORDER : ST_DIV_START;
            end else begin
               state_in = ST_EDGE_DONE;
            end
         end
         ST_DIV_START:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:    if (status.div_done) state_in = ST_EMIT_BORDER;
         ST_EMIT_BORDER: begin
            if (status.out_free) begin
               state_in = status.cin ? ST_EMIT_CUR : ST_EDGE_DONE;
            end
         end
         ST_EMIT_CUR:    if (status.out_free) state_in = ST_EDGE_DONE;
         ST_EDGE_DONE: begin
            if (status.last && !edge_close_ff) begin
               edge_close_in = 1'b1;
               state_in      = ST_EDGE_LOAD;
            end else if (status.last) begin
               state_in = ST_EMIT_TRAILER;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_TRAILER: begin
            if (status.out_free) begin
               have_first_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.out_src    = OUT_CUR;
      cmd.edge_close = edge_close_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.cap_in    = accept;
            cmd.set_first = accept && !have_first_ff;
         end
         ST_EDGE_LOAD: cmd.load_edge = 1'b1;
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_EMIT_BORDER: begin
            // a border point ends the item only on a leaving main edge
            cmd.out_load  = status.out_free;
            cmd.out_src   = OUT_BORDER;
            cmd.out_olast = !status.last && !status.cin;
         end
         ST_EMIT_CUR: begin
            cmd.out_load  = status.out_free;
            cmd.out_src   = OUT_CUR;
            cmd.out_olast = !status.last;
         end
         ST_EMIT_TRAILER: begin
            cmd.out_load  = status.out_free;
            cmd.out_src   = OUT_TRAILER;
            cmd.out_olast = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_first_ff <= 1'b0;
         edge_close_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_first_ff <= have_first_in;
         edge_close_ff <= edge_close_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output word loaded over a pending one");

   a_div_on_crossing: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (status.pin != status.cin) && !status.near)
      else $error("interpolation started on a non-crossing edge");

   a_trailer_ends_polygon: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_src == OUT_TRAILER) |=> !have_first_ff && req_tready)
      else $error("polygon not closed after trailer");

endmodule

// ===== hw/rtl/polygon_near_plane_clip_core.sv =====
// Near-plane polygon clipper. Vertices of a polygon arrive one word at a time
// on the req_ channel (x, y, z in signed Q16.16, tlast on the final vertex) and
// are clipped against z = min_z, keeping z >= min_z. Each vertex handles the
// edge from the previous vertex; the final vertex also handles the closing
// edge back to the first one and then sends a trailer word (tuser high) with
// the emitted vertex count and a kept flag. rsp_tlast marks the last word
// caused by an input vertex. min_z and near_eps are to be written by the user on the
// csr_ port only while the block is idle; the block itself does not enforce this.
// One vertex is taken at a time. An edge is classified in the load, distance, sum and
// decide steps; a crossing edge whose distance sum is not below near_eps adds the
// interpolation (a 32x32 multiply and a 32-step restoring divide, x and y in parallel
// units), and each output word waits until the output register is free.
// Reset clears the polygon state and both registers to zero; no sweep follows.
// While the receiver stalls, the pending output word holds and the clipper
// waits at its next emission, so no further input is taken while it waits.
module polygon_near_plane_clip_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,  // vx, vy, vz
   input  logic                  req_tlast,  // vlast
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [111:0]          rsp_tdata,  // ox, oy, oz, kept, vertex_count, zero fill
   output logic                  rsp_tuser,  // kind
   output logic                  rsp_tlast,  // olast
   input  logic                  csr_wen,
   input  npc_pkg::csr_addr_type csr_addr,
   input  logic [31:0]           csr_wdata
);
   import npc_pkg::*;

   cmd_type    cmd;
   status_type status;

   npc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   npc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
